// ===== rtl/afts_pkg.sv =====
// ----------------------------------------------------------------------------
// afts_pkg
// Shared types, register indexes, reset values and frame kind codes of the
// acked frame transmit scheduler.
// ----------------------------------------------------------------------------
package afts_pkg;

  // default sizes handed to the top level parameters
  localparam int SECURE_QUEUE_DEPTH_DEF = 8;
  localparam int TIMER_WIDTH_DEF        = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPS_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPS_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPS_RETRY_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_TRAIN      = 2'd3;

  // configuration reset values
  localparam logic        SPS_ENABLE_RST      = 1'b1;
  localparam logic [15:0] SPS_TIMEOUT_RST     = 16'd1000;
  localparam logic [7:0]  SPS_RETRY_LIMIT_RST = 8'd3;
  localparam logic [7:0]  POLL_TRAIN_RST      = 8'd3;

  // kinds of frame started by one pass
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_ACK    = 3'd1;
  localparam logic [2:0] KIND_SECURE = 3'd2;
  localparam logic [2:0] KIND_NORMAL = 3'd3;
  localparam logic [2:0] KIND_POLL   = 3'd4;

  // one service pass request
  typedef struct packed {
    logic       tick;
    logic       ack_arrived;
    logic       secure_arrived;
    logic       poll_due;
    logic [3:0] secure_queue_count;
    logic       normal_queue_nonempty;
    logic       frame_available;
    logic       tx_room;
    logic [7:0] rx_bytes_pending;
  } afts_in_t;

  // one service pass result
  typedef struct packed {
    logic [2:0] send_kind;
    logic [7:0] poll_length;
    logic       seq_bit;
    logic       mark_secure;
    logic       insert_empty_secure;
    logic       release_secure;
    logic       acked_event;
    logic       unexpected_ack;
    logic       give_up_event;
    logic       underflow_event;
  } afts_out_t;

  // configuration register file contents
  typedef struct packed {
    logic        sps_enable;
    logic [15:0] sps_timeout;
    logic [7:0]  sps_retry_limit;
    logic [7:0]  poll_train;
  } afts_cfg_t;

  // secure machine events of one pass
  typedef struct packed {
    logic seq_bit;
    logic mark_secure;
    logic insert_empty_secure;
    logic release_secure;
    logic acked_event;
    logic unexpected_ack;
    logic give_up_event;
  } afts_evt_t;

  // pending frame requests seen by the frame picker
  typedef struct packed {
    logic       ack_send;
    logic       secure_send;
    logic       poll_send;
    logic       queue_nonzero;
    logic       normal_queue_nonempty;
    logic       tx_room;
    logic [7:0] rx_bytes_pending;
    logic [7:0] poll_train;
  } afts_pick_req_t;

  // frame picker decision
  typedef struct packed {
    logic       ack_clr;
    logic       secure_clr;
    logic       poll_clr;
    logic       underflow;
    logic [2:0] send_kind;
    logic [7:0] poll_length;
  } afts_pick_rsp_t;

endpackage

// ===== rtl/acked_frame_tx_scheduler.sv =====
// ----------------------------------------------------------------------------
// acked_frame_tx_scheduler
// Top level: input register, one service pass, result register.
// ----------------------------------------------------------------------------
// Each accepted item is one service pass of the frame transmitter and gives
// exactly one result. A pass sits in the input register, where the secure
// machine, timer and frame picker settle in one step, and its result is
// registered in the result register when the pass advances; one pass per
// cycle is sustained while out_stall stays low. The state update of the
// secure machine and its flags, done once per pass, sets that rate; a
// stalled result holds the pass behind it in the input register.
// Configuration writes are always taken (cfg_ready is high) and take effect
// on the next pass; a timeout write does not reload a running timer.
// ----------------------------------------------------------------------------
module acked_frame_tx_scheduler #(
  parameter int SECURE_QUEUE_DEPTH = afts_pkg::SECURE_QUEUE_DEPTH_DEF,
  parameter int TIMER_WIDTH        = afts_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  afts_pkg::afts_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output afts_pkg::afts_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [afts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  afts_pkg::afts_in_t       in_data_r;
  logic                     in_vld_r, in_vld_nxt;
  afts_pkg::afts_out_t      out_data_r, out_data_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic                     advance;
  logic                     in_take;
  afts_pkg::afts_cfg_t      cfg;
  afts_pkg::afts_pick_req_t pick_req;
  afts_pkg::afts_pick_rsp_t pick_rsp;
  afts_pkg::afts_evt_t      evt;

  assign cfg_ready = 1'b1;

  afts_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  afts_core #(
    .SECURE_QUEUE_DEPTH (SECURE_QUEUE_DEPTH),
    .TIMER_WIDTH        (TIMER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (in_data_r),
    .cfg      (cfg),
    .pick_rsp (pick_rsp),
    .pick_req (pick_req),
    .evt      (evt)
  );

  afts_pick u_pick (
    .req (pick_req),
    .rsp (pick_rsp)
  );

  // pass moves on when the result register is free or being emptied
  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  // valid tracking of both registers
  always_comb begin
    in_vld_nxt = in_take | (in_vld_r & ~advance);
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else begin
      out_vld_nxt = out_vld_r & out_stall;
    end
  end

  // result assembly
  always_comb begin
    out_data_nxt.send_kind           = pick_rsp.send_kind;
    out_data_nxt.poll_length         = pick_rsp.poll_length;
    out_data_nxt.seq_bit             = evt.seq_bit;
    out_data_nxt.mark_secure         = evt.mark_secure;
    out_data_nxt.insert_empty_secure = evt.insert_empty_secure;
    out_data_nxt.release_secure      = evt.release_secure;
    out_data_nxt.acked_event         = evt.acked_event;
    out_data_nxt.unexpected_ack      = evt.unexpected_ack;
    out_data_nxt.give_up_event       = evt.give_up_event;
    out_data_nxt.underflow_event     = pick_rsp.underflow;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/afts_cfg.sv =====
// ----------------------------------------------------------------------------
// afts_cfg
// Configuration registers of the scheduler, written by index.
// ----------------------------------------------------------------------------
module afts_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [afts_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [31:0]                      wr_data,
  output afts_pkg::afts_cfg_t              cfg
);

  afts_pkg::afts_cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sps_enable      <= afts_pkg::SPS_ENABLE_RST;
      cfg_r.sps_timeout     <= afts_pkg::SPS_TIMEOUT_RST;
      cfg_r.sps_retry_limit <= afts_pkg::SPS_RETRY_LIMIT_RST;
      cfg_r.poll_train      <= afts_pkg::POLL_TRAIN_RST;
    end else if (wr_en) begin
      case (wr_index)
        afts_pkg::CFG_SPS_ENABLE:      cfg_r.sps_enable      <= wr_data[0];
        afts_pkg::CFG_SPS_TIMEOUT:     cfg_r.sps_timeout     <= wr_data[15:0];
        afts_pkg::CFG_SPS_RETRY_LIMIT: cfg_r.sps_retry_limit <= wr_data[7:0];
        afts_pkg::CFG_POLL_TRAIN:      cfg_r.poll_train      <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/afts_pick.sv =====
// ----------------------------------------------------------------------------
// afts_pick
// Fixed priority frame picker: ack, secure, normal, poll.
// ----------------------------------------------------------------------------
module afts_pick (
  input  afts_pkg::afts_pick_req_t req,
  output afts_pkg::afts_pick_rsp_t rsp
);

  always_comb begin
    rsp             = '0;
    rsp.send_kind   = afts_pkg::KIND_NONE;
    if (req.ack_send) begin
      // ack waits for room
      if (req.tx_room) begin
        rsp.send_kind = afts_pkg::KIND_ACK;
        rsp.ack_clr   = 1'b1;
      end
    end else if (req.secure_send) begin
      // secure send with an empty queue is dropped as underflow
      if (req.queue_nonzero) begin
        if (req.tx_room) begin
          rsp.send_kind  = afts_pkg::KIND_SECURE;
          rsp.secure_clr = 1'b1;
        end
      end else begin
        rsp.secure_clr = 1'b1;
        rsp.underflow  = 1'b1;
      end
    end else if (req.normal_queue_nonempty) begin
      if (req.tx_room) begin
        rsp.send_kind = afts_pkg::KIND_NORMAL;
      end
    end else if (req.poll_send) begin
      // poll is dropped when the transmitter is busy
      rsp.poll_clr = 1'b1;
      if (req.tx_room) begin
        rsp.send_kind   = afts_pkg::KIND_POLL;
        rsp.poll_length = (req.rx_bytes_pending > req.poll_train) ?
                          req.rx_bytes_pending : req.poll_train;
      end
    end
  end

endmodule

// ===== rtl/afts_core.sv =====
// ----------------------------------------------------------------------------
// afts_core
// Event latches, secure timer and the alternating-bit secure frame machine.
// ----------------------------------------------------------------------------
module afts_core #(
  parameter int SECURE_QUEUE_DEPTH = afts_pkg::SECURE_QUEUE_DEPTH_DEF,
  parameter int TIMER_WIDTH        = afts_pkg::TIMER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  afts_pkg::afts_in_t       item,
  input  afts_pkg::afts_cfg_t      cfg,
  input  afts_pkg::afts_pick_rsp_t pick_rsp,
  output afts_pkg::afts_pick_req_t pick_req,
  output afts_pkg::afts_evt_t      evt
);

  localparam int CNT_W_MIN = $clog2(SECURE_QUEUE_DEPTH + 1);
  localparam int CNT_W     = (CNT_W_MIN > 4) ? CNT_W_MIN : 4;
  localparam logic [CNT_W-1:0] QDEPTH = CNT_W'(SECURE_QUEUE_DEPTH);
  localparam int EXT_W = TIMER_WIDTH + 16;
  localparam logic [EXT_W-1:0] TMR_RST_EXT = EXT_W'(afts_pkg::SPS_TIMEOUT_RST);

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_READY0 = 3'd1,
    ST_READY1 = 3'd2,
    ST_WAIT0  = 3'd3,
    ST_WAIT1  = 3'd4
  } sps_state_t;

  sps_state_t             state_r, state_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [7:0]             retry_r, retry_nxt;
  logic                   ack_pend_r, ack_pend_nxt;
  logic                   ack_send_r;
  logic                   secure_send_r;
  logic                   poll_send_r;

  logic [EXT_W-1:0]       reload_ext;
  logic [TIMER_WIDTH-1:0] reload;
  logic [CNT_W-1:0]       cnt;
  logic                   ack_send_c;
  logic                   secure_send_c;
  logic                   poll_send_c;
  logic                   expired;

  // reload value masked to the timer width
  assign reload_ext = EXT_W'(cfg.sps_timeout);
  assign reload     = reload_ext[TIMER_WIDTH-1:0];

  // one pass of the secure machine
  always_comb begin
    cnt = CNT_W'(item.secure_queue_count);
    if (cnt > QDEPTH) begin
      cnt = QDEPTH;
    end
    ack_pend_nxt  = ack_pend_r | item.ack_arrived;
    ack_send_c    = ack_send_r | item.secure_arrived;
    poll_send_c   = poll_send_r | item.poll_due;
    secure_send_c = secure_send_r;
    timer_nxt     = timer_r;
    if (item.tick && (timer_r != '0)) begin
      timer_nxt = timer_r - 1'b1;
    end
    case (state_r)
      ST_READY0, ST_READY1, ST_WAIT0, ST_WAIT1: state_nxt = state_r;
      default:                                  state_nxt = ST_NONE;
    endcase
    retry_nxt = retry_r;
    evt       = '0;
    expired   = 1'b0;

    if (cfg.sps_enable) begin
      // consume a pending ack
      if (ack_pend_nxt) begin
        ack_pend_nxt    = 1'b0;
        evt.acked_event = 1'b1;
        case (state_nxt)
          ST_NONE: state_nxt = ST_READY0;
          ST_READY0, ST_READY1: evt.unexpected_ack = 1'b1;
          default: begin
            if (cnt != '0) begin
              cnt                = cnt - 1'b1;
              evt.release_secure = 1'b1;
            end
            state_nxt = (state_nxt == ST_WAIT0) ? ST_READY1 : ST_READY0;
          end
        endcase
      end

      expired = (timer_nxt == '0);
      case (state_nxt)
        // idle: start an empty secure frame after the timeout
        ST_NONE: begin
          if (expired) begin
            if (item.frame_available && (cnt < QDEPTH)) begin
              cnt                     = cnt + 1'b1;
              evt.insert_empty_secure = 1'b1;
              state_nxt               = ST_READY0;
            end else begin
              timer_nxt = reload;
            end
          end
        end
        // ready: mark the queue head and send it
        ST_READY0, ST_READY1: begin
          if (cnt != '0) begin
            timer_nxt       = reload;
            evt.mark_secure = 1'b1;
            evt.seq_bit     = (state_nxt == ST_READY1);
            state_nxt       = (state_nxt == ST_READY0) ? ST_WAIT0 : ST_WAIT1;
            secure_send_c   = 1'b1;
            retry_nxt       = '0;
          end
        end
        // waiting for ack: resend or give up
        default: begin
          if (expired) begin
            if (retry_r < cfg.sps_retry_limit) begin
              timer_nxt     = reload;
              retry_nxt     = retry_r + 1'b1;
              secure_send_c = 1'b1;
            end else begin
              if (cnt != '0) begin
                cnt                = cnt - 1'b1;
                evt.release_secure = 1'b1;
              end
              state_nxt         = ST_NONE;
              evt.give_up_event = 1'b1;
              if (cnt == '0) begin
                secure_send_c = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  // requests for the frame picker
  always_comb begin
    pick_req.ack_send              = ack_send_c;
    pick_req.secure_send           = secure_send_c;
    pick_req.poll_send             = poll_send_c;
    pick_req.queue_nonzero         = (cnt != '0);
    pick_req.normal_queue_nonempty = item.normal_queue_nonempty;
    pick_req.tx_room               = item.tx_room;
    pick_req.rx_bytes_pending      = item.rx_bytes_pending;
    pick_req.poll_train            = cfg.poll_train;
  end

  // machine state, timer and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_NONE;
      timer_r       <= TMR_RST_EXT[TIMER_WIDTH-1:0];
      retry_r       <= '0;
      ack_pend_r    <= 1'b0;
      ack_send_r    <= 1'b0;
      secure_send_r <= 1'b0;
      poll_send_r   <= 1'b0;
    end else if (step) begin
      state_r       <= state_nxt;
      timer_r       <= timer_nxt;
      retry_r       <= retry_nxt;
      ack_pend_r    <= ack_pend_nxt;
      ack_send_r    <= ack_send_c & ~pick_rsp.ack_clr;
      secure_send_r <= secure_send_c & ~pick_rsp.secure_clr;
      poll_send_r   <= poll_send_c & ~pick_rsp.poll_clr;
    end
  end

endmodule

// ===== rtl/afts_chk.sv =====
// ----------------------------------------------------------------------------
// afts_chk
// Port level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module afts_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input afts_pkg::afts_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // poll length only goes with a poll frame
  a_poll_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.send_kind != afts_pkg::KIND_POLL) |->
      out_data.poll_length == 8'd0)
    else $error("poll length without poll frame");

  // sequence bit only with a header rewrite
  a_seq_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.seq_bit |-> out_data.mark_secure)
    else $error("sequence bit without mark");

  // an unexpected ack is still a consumed ack
  a_unexp_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unexpected_ack |-> out_data.acked_event)
    else $error("unexpected ack without ack event");

  // underflow starts no frame
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.underflow_event |->
      out_data.send_kind == afts_pkg::KIND_NONE)
    else $error("frame started on underflow");

endmodule

bind acked_frame_tx_scheduler afts_chk u_afts_chk (.*);
